// File: design/ttg_pkg.sv
`timescale 1ns / 1ps

package ttg_pkg;

	// system clock the tone is derived from
	localparam int CLOCK_HZ = 8000000;

	// field widths
	localparam int FREQ_W  = 16;
	localparam int CODE_W  = 3;
	localparam int CMP_W   = 8;
	localparam int PRESC_W = 10;
	localparam int SHIFT_W = 4;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// divider: half the clock divided by the frequency, one quotient bit a cycle
	localparam int DIVIDEND = CLOCK_HZ / 2;
	localparam int QUOT_W   = $clog2(DIVIDEND + 1);
	localparam int CNT_W    = $clog2(QUOT_W);

	localparam int NUM_PRESC = 7;

	localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(NUM_PRESC);
	localparam logic [CMP_W-1:0]  CMP_MAX    = {CMP_W{1'b1}};
	localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000);

	// register indexes, decoded from the word address
	localparam logic REG_ENABLE    = 1'b0;
	localparam logic REG_FREQUENCY = 1'b1;

	// configuration events seen by the controller
	typedef struct packed {
		logic en_rise;    // enable written to 1 from 0
		logic run_clear;  // stop or restart: clear level and counters
	} ttg_cfg_ev_t;

	// controller to datapath
	typedef struct packed {
		logic snap;         // capture frequency for a pending start
		logic use_snap;     // search target is the captured frequency
		logic div_load;     // latch divisor and dividend
		logic div_step;     // one quotient bit
		logic res_load;     // pick prescale from quotient
		logic chosen_load;  // copy search result into live setting
		logic item_step;    // request accepted
		logic run_clear;
	} ttg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tag_match;    // stored search result belongs to the target frequency
	} ttg_stat_t;

	// right shift that matches prescale code 1..7 (1,8,32,64,128,256,1024)
	function automatic logic [SHIFT_W-1:0] presc_shift(input logic [CODE_W-1:0] code);
		logic [SHIFT_W-1:0] sh;
		case (code)
			3'd1:    sh = 4'd0;
			3'd2:    sh = 4'd3;
			3'd3:    sh = 4'd5;
			3'd4:    sh = 4'd6;
			3'd5:    sh = 4'd7;
			3'd6:    sh = 4'd8;
			3'd7:    sh = 4'd10;
			default: sh = 4'd6;
		endcase
		return sh;
	endfunction

	// last prescaler count before the timer advances (prescale minus one)
	function automatic logic [PRESC_W-1:0] presc_last(input logic [CODE_W-1:0] code);
		logic [SHIFT_W-1:0] sh;
		sh = presc_shift(code);
		return {PRESC_W{1'b1}} >> (SHIFT_W'(PRESC_W) - sh);
	endfunction

endpackage

// File: design/timer_tone_generator_unit.sv
`timescale 1ns / 1ps
// A result is registered and presented in the cycle after its request is taken.
// Throughput: one tick request per cycle while the divider search is settled and
// the output slot is free. After reset or a frequency write, the divider search
// (one quotient bit a cycle through a restoring divider) stalls requests; an
// enable start stalls them while the chosen setting is loaded.
// Reset: enable 0, frequency 1000, level and counters clear, code 7, compare 255.

module timer_tone_generator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ttg_pkg::ADDR_W-1:0] paddr,
	input  logic [ttg_pkg::DATA_W-1:0] pwdata,
	output logic [ttg_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	// tick requests
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       tick,
	// results
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       tone_level,
	output logic [ttg_pkg::CODE_W-1:0] prescale_code,
	output logic [ttg_pkg::CMP_W-1:0]  compare_value,
	output logic                       out_of_range
);
	import ttg_pkg::*;

	logic              enable_q;
	logic [FREQ_W-1:0] frequency_q;
	logic              wr;
	logic              reg_idx;
	ttg_cfg_ev_t       cfg_ev;
	ttg_cmd_t          cmd;
	ttg_stat_t         stat;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign reg_idx = paddr[2];

	// start and stop events from enable writes
	assign cfg_ev.en_rise   = wr && (reg_idx == REG_ENABLE) && pwdata[0] && !enable_q;
	assign cfg_ev.run_clear = wr && (reg_idx == REG_ENABLE) && (!pwdata[0] || !enable_q);

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			frequency_q <= FREQ_RESET;
		end else if (wr) begin
			unique case (reg_idx)
				REG_ENABLE:    enable_q    <= pwdata[0];
				REG_FREQUENCY: frequency_q <= pwdata[FREQ_W-1:0];
				default:       enable_q    <= enable_q;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, enable_q};
			REG_FREQUENCY: prdata = {{(DATA_W-FREQ_W){1'b0}}, frequency_q};
			default:       prdata = '0;
		endcase
	end

	ttg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_ev    (cfg_ev),
		.stat      (stat),
		.cmd       (cmd)
	);

	ttg_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.frequency     (frequency_q),
		.enable        (enable_q),
		.tick          (tick),
		.stat          (stat),
		.tone_level    (tone_level),
		.prescale_code (prescale_code),
		.compare_value (compare_value),
		.out_of_range  (out_of_range)
	);

`ifndef ASSERT_OFF
	// stopped tone reads low
	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !enable_q) |-> !tone_level)
		else $error("tone level high while disabled");

	// fallback setting goes with the flag
	a_range_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		out_of_range |-> ((prescale_code == CODE_MAX) && (compare_value == CMP_MAX)))
		else $error("out of range without fallback setting");

	// no prescale code zero ever reaches the output
	a_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (prescale_code != '0))
		else $error("prescale code zero");

	// requests only taken against a settled search
	a_ready_settled: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> stat.tag_match)
		else $error("request taken during divider search");
`endif

endmodule

// File: design/ttg_ctrl.sv
`timescale 1ns / 1ps

module ttg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ttg_pkg::ttg_cfg_ev_t cfg_ev,
	input  ttg_pkg::ttg_stat_t stat,
	output ttg_pkg::ttg_cmd_t  cmd
);
	import ttg_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_PICK
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               srch_ok_q;
	logic               pend_q;
	logic               out_valid_q;
	logic               hit;
	logic               accept;

	// search result is usable when finished and for the right frequency
	assign hit = srch_ok_q && stat.tag_match;

	assign in_ready  = (state_q == S_IDLE) && hit && !pend_q && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// decode commands
	always_comb begin
		cmd             = '0;
		cmd.snap        = cfg_ev.en_rise;
		cmd.use_snap    = pend_q;
		cmd.div_load    = (state_q == S_IDLE) && !hit;
		cmd.div_step    = (state_q == S_DIV);
		cmd.res_load    = (state_q == S_PICK);
		cmd.chosen_load = (state_q == S_IDLE) && hit && pend_q;
		cmd.item_step   = accept;
		cmd.run_clear   = cfg_ev.run_clear;
	end

	// sequence the search, hold pending start and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			srch_ok_q   <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!hit) begin
						state_q   <= S_DIV;
						cnt_q     <= '0;
						srch_ok_q <= 1'b0;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= S_PICK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_PICK: begin
					state_q   <= S_IDLE;
					srch_ok_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_ev.en_rise) begin
				pend_q <= 1'b1;
			end else if (cmd.chosen_load) begin
				pend_q <= 1'b0;
			end

			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/ttg_dpath.sv
`timescale 1ns / 1ps

module ttg_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ttg_pkg::ttg_cmd_t          cmd,
	input  logic [ttg_pkg::FREQ_W-1:0] frequency,
	input  logic                       enable,
	input  logic                       tick,
	output ttg_pkg::ttg_stat_t         stat,
	output logic                       tone_level,
	output logic [ttg_pkg::CODE_W-1:0] prescale_code,
	output logic [ttg_pkg::CMP_W-1:0]  compare_value,
	output logic                       out_of_range
);
	import ttg_pkg::*;

	// search unit
	logic [FREQ_W-1:0]  snap_q;
	logic [FREQ_W-1:0]  divisor_q;
	logic [FREQ_W-1:0]  target;
	logic [FREQ_W-1:0]  rem_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [FREQ_W:0]    shifted;
	logic [FREQ_W+1:0]  diff;
	logic               ge;
	logic [QUOT_W-1:0]  qs;
	logic [CODE_W-1:0]  pick_code;
	logic [CMP_W-1:0]   pick_cmp;
	logic               pick_flag;
	logic [CODE_W-1:0]  srch_code_q;
	logic [CMP_W-1:0]   srch_cmp_q;
	logic               srch_flag_q;

	// live tone state
	logic [CODE_W-1:0]  code_q;
	logic [CMP_W-1:0]   cmp_q;
	logic               flag_q;
	logic               level_q;
	logic [PRESC_W-1:0] presc_q;
	logic [CMP_W-1:0]   timer_q;

	assign target         = cmd.use_snap ? snap_q : frequency;
	assign stat.tag_match = (divisor_q == target);

	// restoring division step
	assign shifted = {rem_q, quot_q[QUOT_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
	assign ge      = !diff[FREQ_W+1];

	// first prescale whose quotient lies in 1..compare max + 1
	always_comb begin
		pick_code = CODE_MAX;
		pick_cmp  = CMP_MAX;
		pick_flag = 1'b1;
		qs        = '0;
		for (int i = NUM_PRESC - 1; i >= 0; i--) begin
			qs = quot_q >> presc_shift(CODE_W'(i + 1));
			if ((qs != '0) && ((qs - 1'b1) <= QUOT_W'(CMP_MAX))) begin
				pick_code = CODE_W'(i + 1);
				pick_cmp  = CMP_W'(qs - 1'b1);
				pick_flag = 1'b0;
			end
		end
		if (divisor_q == '0) begin
			pick_code = CODE_MAX;
			pick_cmp  = CMP_MAX;
			pick_flag = 1'b1;
		end
	end

	// divider and search result registers
	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			snap_q <= frequency;
		end
		if (cmd.div_load) begin
			divisor_q <= target;
			rem_q     <= '0;
			quot_q    <= QUOT_W'(DIVIDEND);
		end else if (cmd.div_step) begin
			rem_q  <= ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
		if (cmd.res_load) begin
			srch_code_q <= pick_code;
			srch_cmp_q  <= pick_cmp;
			srch_flag_q <= pick_flag;
		end
	end

	// tone state: idle requests reload the setting, running requests advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q  <= CODE_MAX;
			cmp_q   <= CMP_MAX;
			flag_q  <= 1'b0;
			level_q <= 1'b0;
			presc_q <= '0;
			timer_q <= '0;
		end else begin
			if (cmd.chosen_load) begin
				code_q <= srch_code_q;
				cmp_q  <= srch_cmp_q;
				flag_q <= srch_flag_q;
			end
			if (cmd.run_clear) begin
				level_q <= 1'b0;
				presc_q <= '0;
				timer_q <= '0;
			end else if (cmd.item_step) begin
				if (!enable) begin
					code_q  <= srch_code_q;
					cmp_q   <= srch_cmp_q;
					flag_q  <= srch_flag_q;
					level_q <= 1'b0;
					presc_q <= '0;
					timer_q <= '0;
				end else if (tick) begin
					if (presc_q >= presc_last(code_q)) begin
						presc_q <= '0;
						if (timer_q >= cmp_q) begin
							timer_q <= '0;
							level_q <= !level_q;
						end else begin
							timer_q <= timer_q + 1'b1;
						end
					end else begin
						presc_q <= presc_q + 1'b1;
					end
				end
			end
		end
	end

	assign tone_level    = level_q;
	assign prescale_code = code_q;
	assign compare_value = cmp_q;
	assign out_of_range  = flag_q;

endmodule
